/* sv/neighbour_table_parent_select_top_macros.svh */
// Assertion macros for the neighbour table and parent select block.
`ifndef NEIGHBOUR_TABLE_PARENT_SELECT_TOP_MACROS_SVH
`define NEIGHBOUR_TABLE_PARENT_SELECT_TOP_MACROS_SVH
`ifndef SYNTH
// checked outside reset
`define NTPS_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);
// checked during reset too
`define NTPS_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk_i) (prop)) else $error(msg);
`else
`define NTPS_ASSERT(label, prop, msg)
`define NTPS_ASSERT_ALWAYS(label, prop, msg)
`endif
`endif

/* sv/ntps_pkg.sv */
// Types, constants and helper functions of the neighbour table and parent select block.
package ntps_pkg;

  localparam int unsigned TABLE_DEPTH_DEF = 32;
  localparam int unsigned ADDR_W     = 8;
  localparam int unsigned TIME_W     = 32;
  localparam int unsigned RAND_W     = 16;
  localparam int unsigned MOD_W      = 9;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 16;
  localparam int unsigned COUNT_W    = 6;

  localparam logic signed [7:0] RSSI_FLOOR  = -8'sd128;
  localparam logic [RAND_W-1:0] LFSR_TAPS   = 16'hB400;
  localparam logic [MOD_W-1:0]  RAND_MOD    = 9'd101;
  localparam logic [MOD_W-1:0]  RAND_THRESH = 9'd50;

  localparam logic [ADDR_W-1:0]     OWN_RST     = 8'd1;
  localparam logic [ADDR_W-1:0]     SINK_RST    = 8'd0;
  localparam logic [ADDR_W-1:0]     BCAST_RST   = 8'd255;
  localparam logic [2:0]            STRAT_RST   = 3'd4;
  localparam logic [15:0]           TIMEOUT_RST = 16'd60;
  localparam logic [RAND_W-1:0]     SEED_RST    = 16'd44257;

  typedef enum logic [1:0] {
    OP_HEARD   = 2'd0,
    OP_CLEANUP = 2'd1,
    OP_LOOP    = 2'd2,
    OP_NONE    = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    ROLE_PARENT = 2'd0,
    ROLE_CHILD  = 2'd1,
    ROLE_NODE   = 2'd2
  } role_e;

  typedef enum logic [2:0] {
    STRAT_RAND_LOWER    = 3'd0,
    STRAT_RAND          = 3'd1,
    STRAT_NEXT_LOWER    = 3'd2,
    STRAT_CLOSEST       = 3'd3,
    STRAT_CLOSEST_LOWER = 3'd4
  } strat_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_OWN     = 3'd0,
    REG_SINK    = 3'd1,
    REG_BCAST   = 3'd2,
    REG_STRAT   = 3'd3,
    REG_TIMEOUT = 3'd4,
    REG_SEED    = 3'd5
  } reg_e;

  typedef struct packed {
    logic [1:0]        operation;
    logic [ADDR_W-1:0] neighbour_address;
    logic signed [7:0] rssi;
    logic [ADDR_W-1:0] advertised_parent;
    logic [TIME_W-1:0] now_seconds;
  } in_item_t;

  typedef struct packed {
    logic [ADDR_W-1:0]  parent_address;
    logic               parent_changed;
    logic [COUNT_W-1:0] active_count;
    logic               status;
  } out_item_t;

  typedef struct packed {
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] value;
  } cfg_wr_t;

  typedef struct packed {
    logic              active;
    logic [1:0]        role;
    logic signed [7:0] rssi;
    logic [ADDR_W-1:0] parent;
    logic [TIME_W-1:0] seen;
  } entry_t;

  typedef struct packed {
    logic              start;
    logic [RAND_W-1:0] dividend;
    logic [MOD_W-1:0]  divisor;
  } mod_req_t;

  typedef struct packed {
    logic             done;
    logic [MOD_W-1:0] remainder;
  } mod_rsp_t;

  // value of an entry that was never written since reset
  function automatic entry_t entry_reset(logic [ADDR_W-1:0] idx);
    entry_t e;
    e = '0;
    if (idx == SINK_RST) e.rssi = RSSI_FLOOR;
    return e;
  endfunction

  function automatic logic [RAND_W-1:0] lfsr_next(logic [RAND_W-1:0] s);
    logic [RAND_W-1:0] n;
    n = s >> 1;
    if (s[0]) n = n ^ LFSR_TAPS;
    return n;
  endfunction

endpackage

/* sv/ntps_chan_if.sv */
// Valid/ready channel interface with a typed payload.
interface ntps_chan_if #(
  parameter type T = logic
) ();
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

/* sv/ntps_mod_unit.sv */
// Bit-serial remainder unit: 16-bit dividend modulo a 9-bit divisor, one bit per cycle.
module ntps_mod_unit (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  ntps_pkg::mod_req_t req_i,
  output ntps_pkg::mod_rsp_t rsp_o
);

  logic                           busy_q, busy_d;
  logic                           done_q, done_d;
  logic [3:0]                     cnt_q, cnt_d;
  logic [ntps_pkg::RAND_W-1:0]    num_q, num_d;
  logic [ntps_pkg::MOD_W-1:0]     div_q, div_d;
  logic [ntps_pkg::MOD_W-1:0]     rem_q, rem_d;
  logic [ntps_pkg::MOD_W:0]       trial;

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    num_d  = num_q;
    div_d  = div_q;
    rem_d  = rem_q;
    trial  = {rem_q, num_q[ntps_pkg::RAND_W-1]};
    if (req_i.start) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      num_d  = req_i.dividend;
      div_d  = req_i.divisor;
      rem_d  = '0;
    end else if (busy_q) begin
      num_d = num_q << 1;
      if (trial >= {1'b0, div_q}) begin
        rem_d = ntps_pkg::MOD_W'(trial - {1'b0, div_q});
      end else begin
        rem_d = ntps_pkg::MOD_W'(trial);
      end
      cnt_d = cnt_q + 4'd1;
      if (cnt_q == 4'd15) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    num_q <= num_d;
    div_q <= div_d;
    rem_q <= rem_d;
  end

  assign rsp_o.done      = done_q;
  assign rsp_o.remainder = rem_q;

endmodule

/* sv/neighbour_table_parent_select_top.sv */
// Neighbour table and routing parent select: top level with table memory and sequencer.
//
//  channel  dir  payload                                             handshake
//  in_i     in   operation, neighbour_address, rssi, adv. parent,    valid/ready
//                now_seconds
//  out_o    out  parent_address, parent_changed, active_count,       valid/ready
//                status
//  cfg_i    in   register index, write data                          valid/ready
//
// One item at a time. Heard reads the parent and neighbour entries, writes the neighbour
// entry and, on a new parent, both parent entries; a random draw test adds a remainder
// check. Cleanup scans the table, one table memory read and write per cycle, adding a
// reselection if the parent expired. Loop reselection scans the table and rewrites the
// old and new parent entries; random strategies add a pool-size remainder and a second
// scan. Reset clears the per-entry valid bits at once, no clearing pass. A result waiting
// on out_o does not block the next input; it stalls only the end of the following item.
`include "neighbour_table_parent_select_top_macros.svh"

module neighbour_table_parent_select_top #(
  parameter int unsigned TABLE_DEPTH = ntps_pkg::TABLE_DEPTH_DEF
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  ntps_chan_if.sink    in_i,
  ntps_chan_if.source  out_o,
  ntps_chan_if.sink    cfg_i
);

  localparam int unsigned IW = $clog2(TABLE_DEPTH);
  localparam int unsigned CW = $clog2(TABLE_DEPTH + 1);
  localparam int unsigned AW = ntps_pkg::ADDR_W;
  localparam int unsigned TIME_W_L = ntps_pkg::TIME_W;
  localparam logic [AW:0]   DEPTH_A = (AW + 1)'(TABLE_DEPTH);
  localparam logic [CW-1:0] DEPTH_C = CW'(TABLE_DEPTH);
  // floor(x / 101) = (x * RECIP_M) >> RECIP_SH, exact for every 16-bit x
  localparam logic [15:0]   RECIP_M  = 16'd41528;
  localparam int unsigned   RECIP_SH = 22;

  typedef enum logic [4:0] {
    S_IDLE, S_H_RDP, S_H_RDA, S_H_UPD, S_H_MODW, S_H_MODR, S_H_TAKE, S_H_OLDP,
    S_C_SCAN, S_R_SCAN, S_R_MODW, S_R_PICK, S_R_RDP, S_R_WRP, S_R_RDN, S_R_WRN,
    S_DONE
  } state_e;

  state_e state_q, state_d;

  ntps_pkg::in_item_t  item_q, item_d;
  ntps_pkg::out_item_t out_q, out_d;
  logic                out_valid_q, out_valid_d;
  logic [AW-1:0]       before_q, before_d;
  logic                status_q, status_d;
  logic [AW-1:0]       parent_q, parent_d;
  logic [CW-1:0]       cnt_q, cnt_d;
  logic [AW-1:0]       last_loop_q, last_loop_d;
  logic [ntps_pkg::RAND_W-1:0] lfsr_q, lfsr_d;
  logic [CW-1:0]       scan_q, scan_d;
  logic [CW-1:0]       n_q, n_d;
  logic [CW-1:0]       m_q, m_d;
  logic [ntps_pkg::MOD_W-1:0] k_q, k_d;
  logic [31-RECIP_SH:0] quo_q, quo_d;
  logic signed [7:0]   best_q, best_d;
  logic [AW-1:0]       chosen_q, chosen_d;
  logic                lost_q, lost_d;
  logic signed [7:0]   prssi_q, prssi_d;
  ntps_pkg::entry_t    pent_q, pent_d;
  ntps_pkg::entry_t    ne_q, ne_d;

  logic [AW-1:0]       own_q, own_d;
  logic [AW-1:0]       sink_q, sink_d;
  logic [AW-1:0]       bcast_q, bcast_d;
  logic [2:0]          strat_q, strat_d;
  logic [15:0]         tmo_q, tmo_d;

  // table memory, one read and one write port, registered read data
  ntps_pkg::entry_t    mem_q [TABLE_DEPTH];
  logic [TABLE_DEPTH-1:0] valid_q;
  logic                rd_en, wr_en;
  logic [IW-1:0]       rd_addr, wr_addr;
  ntps_pkg::entry_t    wr_data;
  ntps_pkg::entry_t    rd_data_q;
  logic                rd_valid_q;
  logic [IW-1:0]       rd_idx_q;
  ntps_pkg::entry_t    entry_rd;

  ntps_pkg::mod_req_t  mod_req;
  ntps_pkg::mod_rsp_t  mod_rsp;

  ntps_mod_unit u_mod (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (mod_req),
    .rsp_o  (mod_rsp)
  );

  always_ff @(posedge clk_i) begin
    if (wr_en) mem_q[wr_addr] <= wr_data;
    if (rd_en) begin
      rd_data_q <= mem_q[rd_addr];
      rd_idx_q  <= rd_addr;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q    <= '0;
      rd_valid_q <= 1'b0;
    end else begin
      if (wr_en) valid_q[wr_addr] <= 1'b1;
      if (rd_en) rd_valid_q <= valid_q[rd_addr];
    end
  end

  assign entry_rd = rd_valid_q ? rd_data_q : ntps_pkg::entry_reset(AW'(rd_idx_q));

  function automatic logic in_tab(logic [AW-1:0] a);
    return {1'b0, a} < DEPTH_A;
  endfunction

  // per-entry scan terms
  logic [AW-1:0] iext;
  logic          usable;
  logic          in_pool;
  logic          scan_proc;
  logic          scan_last;

  assign in_i.ready  = (state_q == S_IDLE);
  assign cfg_i.ready = 1'b1;
  assign out_o.valid = out_valid_q;
  assign out_o.data  = out_q;

  always_comb begin
    logic [AW-1:0]               a;
    logic                        child;
    logic                        take;
    logic [ntps_pkg::RAND_W-1:0] dr;
    ntps_pkg::entry_t            e;
    logic [TIME_W_L-1:0]         age;
    logic [31:0]                 prod;
    logic [15:0]                 rem16;

    a    = item_q.neighbour_address;
    e    = entry_rd;
    dr   = ntps_pkg::lfsr_next(lfsr_q);
    age  = item_q.now_seconds - e.seen;
    prod  = lfsr_q * RECIP_M;
    rem16 = lfsr_q - (16'(quo_q) * 16'(ntps_pkg::RAND_MOD));
    child = 1'b0;
    take  = 1'b0;

    iext      = AW'(rd_idx_q);
    usable    = e.active && (e.role != ntps_pkg::ROLE_CHILD);
    scan_proc = (scan_q != '0);
    scan_last = (scan_q == DEPTH_C);
    if (strat_q == ntps_pkg::STRAT_RAND_LOWER) begin
      in_pool = usable && (iext < own_q) && (iext != sink_q) && (iext < parent_q);
    end else begin
      in_pool = usable && (iext != sink_q) && (iext != parent_q);
    end

    state_d     = state_q;
    item_d      = item_q;
    out_d       = out_q;
    out_valid_d = out_valid_q;
    before_d    = before_q;
    status_d    = status_q;
    parent_d    = parent_q;
    cnt_d       = cnt_q;
    last_loop_d = last_loop_q;
    lfsr_d      = lfsr_q;
    scan_d      = scan_q;
    n_d         = n_q;
    m_d         = m_q;
    k_d         = k_q;
    quo_d       = quo_q;
    best_d      = best_q;
    chosen_d    = chosen_q;
    lost_d      = lost_q;
    prssi_d     = prssi_q;
    pent_d      = pent_q;
    ne_d        = ne_q;
    own_d       = own_q;
    sink_d      = sink_q;
    bcast_d     = bcast_q;
    strat_d     = strat_q;
    tmo_d       = tmo_q;

    rd_en   = 1'b0;
    rd_addr = scan_q[IW-1:0];
    wr_en   = 1'b0;
    wr_addr = rd_idx_q;
    wr_data = e;

    mod_req.start    = 1'b0;
    mod_req.dividend = dr;
    mod_req.divisor  = ntps_pkg::RAND_MOD;

    if (out_valid_q && out_o.ready) out_valid_d = 1'b0;

    case (state_q)
      S_IDLE: begin
        if (in_i.valid) begin
          item_d   = in_i.data;
          before_d = parent_q;
          status_d = 1'b0;
          scan_d   = '0;
          lost_d   = 1'b0;
          n_d      = '0;
          best_d   = ntps_pkg::RSSI_FLOOR;
          chosen_d = sink_q;
          if ((in_i.data.operation == ntps_pkg::OP_HEARD ||
               in_i.data.operation == ntps_pkg::OP_LOOP) &&
              !in_tab(in_i.data.neighbour_address)) begin
            status_d = 1'b1;
            state_d  = S_DONE;
          end else if (in_i.data.operation == ntps_pkg::OP_HEARD) begin
            state_d = S_H_RDP;
          end else if (in_i.data.operation == ntps_pkg::OP_CLEANUP) begin
            state_d = S_C_SCAN;
          end else if (in_i.data.operation == ntps_pkg::OP_LOOP &&
                       in_i.data.neighbour_address != last_loop_q) begin
            last_loop_d = in_i.data.neighbour_address;
            state_d = (own_q > in_i.data.neighbour_address) ? S_R_SCAN : S_DONE;
          end else begin
            state_d = S_DONE;
          end
        end
      end

      S_H_RDP: begin
        rd_en   = in_tab(parent_q);
        rd_addr = parent_q[IW-1:0];
        state_d = S_H_RDA;
      end

      S_H_RDA: begin
        pent_d  = e;
        prssi_d = in_tab(parent_q) ? e.rssi : ntps_pkg::RSSI_FLOOR;
        rd_en   = 1'b1;
        rd_addr = a[IW-1:0];
        state_d = S_H_UPD;
      end

      S_H_UPD: begin
        ne_d        = e;
        ne_d.active = 1'b1;
        if (a == parent_q) begin
          ne_d.role = ntps_pkg::ROLE_PARENT;
        end else if (item_q.advertised_parent == own_q) begin
          ne_d.role = ntps_pkg::ROLE_CHILD;
          child = 1'b1;
        end else begin
          ne_d.role = ntps_pkg::ROLE_NODE;
        end
        if (item_q.advertised_parent != bcast_q) ne_d.parent = item_q.advertised_parent;
        ne_d.rssi = item_q.rssi;
        ne_d.seen = item_q.now_seconds;
        wr_en   = 1'b1;
        wr_addr = a[IW-1:0];
        wr_data = ne_d;
        if (!e.active) cnt_d = cnt_q + 1'b1;
        state_d = S_DONE;
        if (!(own_q == sink_q || child || a == parent_q)) begin
          case (strat_q)
            ntps_pkg::STRAT_RAND_LOWER: begin
              if (a < own_q) begin
                lfsr_d  = dr;
                state_d = S_H_MODW;
              end
            end
            ntps_pkg::STRAT_RAND: begin
              lfsr_d  = dr;
              state_d = S_H_MODW;
            end
            ntps_pkg::STRAT_CLOSEST: take = item_q.rssi > prssi_q;
            ntps_pkg::STRAT_CLOSEST_LOWER: take = (item_q.rssi >= prssi_q) && (a < own_q);
            default: take = (a > parent_q) && (a < own_q);
          endcase
          if (take) state_d = S_H_TAKE;
        end
      end

      // draw / 101 by reciprocal, then remainder against the threshold
      S_H_MODW: begin
        quo_d   = prod[31:RECIP_SH];
        state_d = S_H_MODR;
      end

      S_H_MODR: begin
        state_d = (rem16 < 16'(ntps_pkg::RAND_THRESH)) ? S_H_TAKE : S_DONE;
      end

      S_H_TAKE: begin
        wr_en        = 1'b1;
        wr_addr      = a[IW-1:0];
        wr_data      = ne_q;
        wr_data.role = ntps_pkg::ROLE_PARENT;
        state_d      = S_H_OLDP;
      end

      S_H_OLDP: begin
        wr_en        = in_tab(parent_q);
        wr_addr      = parent_q[IW-1:0];
        wr_data      = pent_q;
        wr_data.role = ntps_pkg::ROLE_NODE;
        parent_d     = a;
        state_d      = S_DONE;
      end

      S_C_SCAN: begin
        rd_en  = !scan_last;
        scan_d = scan_q + 1'b1;
        if (scan_proc && e.active && (item_q.now_seconds >= e.seen) &&
            (age > {16'h0, tmo_q})) begin
          wr_en        = 1'b1;
          wr_data      = e;
          wr_data.active = 1'b0;
          wr_data.role = ntps_pkg::ROLE_NODE;
          if (cnt_q != '0) cnt_d = cnt_q - 1'b1;
          if (parent_q == iext) lost_d = 1'b1;
        end
        if (scan_last) begin
          scan_d  = '0;
          state_d = (lost_d) ? S_R_SCAN : S_DONE;
        end
      end

      S_R_SCAN: begin
        rd_en  = !scan_last;
        scan_d = scan_q + 1'b1;
        if (scan_proc && usable) begin
          case (strat_q)
            ntps_pkg::STRAT_RAND_LOWER, ntps_pkg::STRAT_RAND: begin
              if (in_pool) n_d = n_q + 1'b1;
            end
            ntps_pkg::STRAT_CLOSEST: begin
              if (e.rssi > best_q) begin
                best_d   = e.rssi;
                chosen_d = iext;
              end
            end
            ntps_pkg::STRAT_CLOSEST_LOWER: begin
              if ((iext < own_q) && (e.rssi >= best_q)) begin
                best_d   = e.rssi;
                chosen_d = iext;
              end
            end
            default: begin
              if (iext < own_q) chosen_d = iext;
            end
          endcase
        end
        if (scan_last) begin
          scan_d  = '0;
          state_d = S_R_RDP;
          // pool size includes the last entry, counted this cycle
          if ((strat_q == ntps_pkg::STRAT_RAND_LOWER || strat_q == ntps_pkg::STRAT_RAND) &&
              n_d != '0) begin
            lfsr_d          = dr;
            mod_req.start   = 1'b1;
            mod_req.divisor = ntps_pkg::MOD_W'(n_d);
            state_d         = S_R_MODW;
          end
        end
      end

      S_R_MODW: begin
        if (mod_rsp.done) begin
          k_d     = mod_rsp.remainder;
          m_d     = '0;
          scan_d  = '0;
          state_d = S_R_PICK;
        end
      end

      S_R_PICK: begin
        rd_en  = !scan_last;
        scan_d = scan_q + 1'b1;
        if (scan_proc && in_pool) begin
          if (ntps_pkg::MOD_W'(m_q) == k_q) chosen_d = iext;
          m_d = m_q + 1'b1;
        end
        if (scan_last) begin
          scan_d  = '0;
          state_d = S_R_RDP;
        end
      end

      S_R_RDP: begin
        rd_en   = in_tab(parent_q);
        rd_addr = parent_q[IW-1:0];
        state_d = S_R_WRP;
      end

      S_R_WRP: begin
        wr_en        = in_tab(parent_q);
        wr_addr      = parent_q[IW-1:0];
        wr_data.role = ntps_pkg::ROLE_NODE;
        parent_d     = chosen_q;
        state_d      = S_R_RDN;
      end

      S_R_RDN: begin
        rd_en   = in_tab(parent_q);
        rd_addr = parent_q[IW-1:0];
        state_d = S_R_WRN;
      end

      S_R_WRN: begin
        wr_en        = in_tab(parent_q);
        wr_addr      = parent_q[IW-1:0];
        wr_data.role = ntps_pkg::ROLE_PARENT;
        state_d      = S_DONE;
      end

      S_DONE: begin
        if (!out_valid_q || out_o.ready) begin
          out_valid_d          = 1'b1;
          out_d.parent_address = parent_q;
          out_d.parent_changed = (parent_q != before_q);
          out_d.active_count   = ntps_pkg::COUNT_W'(cnt_q);
          out_d.status         = status_q;
          state_d              = S_IDLE;
        end
      end

      default: state_d = S_IDLE;
    endcase

    if (cfg_i.valid) begin
      case (cfg_i.data.index)
        ntps_pkg::REG_OWN:     own_d   = cfg_i.data.value[AW-1:0];
        ntps_pkg::REG_SINK:    sink_d  = cfg_i.data.value[AW-1:0];
        ntps_pkg::REG_BCAST:   bcast_d = cfg_i.data.value[AW-1:0];
        ntps_pkg::REG_STRAT:   strat_d = cfg_i.data.value[2:0];
        ntps_pkg::REG_TIMEOUT: tmo_d   = cfg_i.data.value;
        ntps_pkg::REG_SEED:    lfsr_d  = cfg_i.data.value;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
      parent_q    <= ntps_pkg::SINK_RST;
      cnt_q       <= '0;
      last_loop_q <= '0;
      lfsr_q      <= ntps_pkg::SEED_RST;
      scan_q      <= '0;
      own_q       <= ntps_pkg::OWN_RST;
      sink_q      <= ntps_pkg::SINK_RST;
      bcast_q     <= ntps_pkg::BCAST_RST;
      strat_q     <= ntps_pkg::STRAT_RST;
      tmo_q       <= ntps_pkg::TIMEOUT_RST;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      parent_q    <= parent_d;
      cnt_q       <= cnt_d;
      last_loop_q <= last_loop_d;
      lfsr_q      <= lfsr_d;
      scan_q      <= scan_d;
      own_q       <= own_d;
      sink_q      <= sink_d;
      bcast_q     <= bcast_d;
      strat_q     <= strat_d;
      tmo_q       <= tmo_d;
    end
  end

  always_ff @(posedge clk_i) begin
    item_q   <= item_d;
    out_q    <= out_d;
    before_q <= before_d;
    status_q <= status_d;
    n_q      <= n_d;
    m_q      <= m_d;
    k_q      <= k_d;
    quo_q    <= quo_d;
    best_q   <= best_d;
    chosen_q <= chosen_d;
    lost_q   <= lost_d;
    prssi_q  <= prssi_d;
    pent_q   <= pent_d;
    ne_q     <= ne_d;
  end

  `NTPS_ASSERT_ALWAYS(a_count_range, cnt_q <= DEPTH_C, "active count exceeds table depth")
  `NTPS_ASSERT(a_mod_done_wait, mod_rsp.done |-> (state_q == S_R_MODW), "remainder done outside a wait state")
  `NTPS_ASSERT(a_accept_leaves_idle, (in_i.valid && in_i.ready) |=> (state_q != S_IDLE), "accepted transaction did not start work")

endmodule
